>>> src/gdfs_pkg.sv
// gdfs_pkg: shared types and constants for the graph depth-first search block.
// Used by gdfs_nbr_ram and graph_depth_first_search; depends on nothing.
`timescale 1ns / 1ps

package gdfs_pkg;

   // fixed field widths of the ports
   localparam int VTX_W    = 4;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // parameter defaults
   localparam int MAX_VERTICES_DEF = 16;
   localparam int MAX_DEGREE_DEF   = 16;

   // a search emits no more than this many results
   localparam int RESULT_LIMIT = 16;
   localparam int RESULT_CNT_W = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR      = 2'd0,
      ACT_ADD_VERTEX = 2'd1,
      ACT_ADD_EDGE   = 2'd2,
      ACT_SEARCH     = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_GRAPH_FULL = 2'd1,
      ST_ABSENT     = 2'd2,
      ST_LIST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FINISH
   } state_type;

   // port bundle of the neighbor memory
   typedef struct packed {
      logic we;
      logic re;
   } ram_ctl_type;

endpackage

>>> src/gdfs_nbr_ram.sv
// gdfs_nbr_ram: neighbor list memory, one write and one registered read port.
// Depends on gdfs_pkg for the entry width and the control bundle.
`timescale 1ns / 1ps

module gdfs_nbr_ram #(
   parameter int DEPTH = gdfs_pkg::MAX_VERTICES_DEF * gdfs_pkg::MAX_DEGREE_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  gdfs_pkg::ram_ctl_type      ctl,
   input  logic [AW-1:0]              waddr,
   input  logic [gdfs_pkg::VTX_W-1:0] wdata,
   input  logic [AW-1:0]              raddr,
   output logic [gdfs_pkg::VTX_W-1:0] rdata_ff
);

   logic [gdfs_pkg::VTX_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ctl.re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

>>> src/graph_depth_first_search.sv
// graph_depth_first_search: directed graph store with iterative depth-first search.
// Depends on gdfs_pkg and gdfs_nbr_ram.
//
//   channel | dir | ports
//   req     | in  | req_valid, req_stall, req_action, req_source_vertex, req_target_vertex
//   rsp     | out | rsp_valid, rsp_stall, rsp_visited_vertex, rsp_last, rsp_status
//
// Clear, add vertex, add edge and a refused search each give one result.
// A search walks neighbor lists through the single memory read port, newest entry
// first: each list entry looked at passes a read state and a check state, and after a
// pop the list below is rescanned from its newest entry; a list is scanned at most
// once per emitted vertex plus once per pop.
// Reset (synchronous) empties the graph and clears all marks.
// A stalled result holds the sequencer; req_stall is high while a search runs.
`timescale 1ns / 1ps

module graph_depth_first_search #(
   parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = gdfs_pkg::MAX_DEGREE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gdfs_pkg::ACTION_W-1:0] req_action,
   input  logic [gdfs_pkg::VTX_W-1:0]    req_source_vertex,
   input  logic [gdfs_pkg::VTX_W-1:0]    req_target_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gdfs_pkg::VTX_W-1:0]    rsp_visited_vertex,
   output logic                          rsp_last,
   output logic [gdfs_pkg::STATUS_W-1:0] rsp_status
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int KW    = $clog2(MAX_DEGREE + 1);
   localparam int DEPTH = MAX_VERTICES * MAX_DEGREE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = CW + gdfs_pkg::VTX_W;

   gdfs_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                    vcount_ff, vcount_in;
   logic [MAX_VERTICES-1:0]          visited_ff, visited_in;
   logic [KW-1:0]                    cnt_ff [MAX_VERTICES];
   logic [KW-1:0]                    cnt_in [MAX_VERTICES];
   logic [gdfs_pkg::VTX_W-1:0]       stack_ff [MAX_VERTICES];
   logic [gdfs_pkg::VTX_W-1:0]       stack_in [MAX_VERTICES];
   logic [CW-1:0]                    depth_ff, depth_in;
   logic [gdfs_pkg::RESULT_CNT_W-1:0] n_ff, n_in;
   logic [gdfs_pkg::VTX_W-1:0]       pend_ff, pend_in;
   logic [VW-1:0]                    cur_ff, cur_in;
   logic [KW-1:0]                    k_ff, k_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [gdfs_pkg::VTX_W-1:0]       rsp_vtx_ff, rsp_vtx_in;
   logic                             rsp_last_ff, rsp_last_in;
   gdfs_pkg::status_type             rsp_status_ff, rsp_status_in;

   gdfs_pkg::ram_ctl_type            ram_ctl;
   logic [AW-1:0]                    ram_waddr, ram_raddr;
   logic [gdfs_pkg::VTX_W-1:0]       ram_rdata;

   gdfs_pkg::action_type             act;
   logic                             out_free;
   logic                             src_ok, dst_ok;
   logic [VW-1:0]                    src_idx, dst_idx, w_idx, below_idx;
   logic [KW-1:0]                    k_dec;
   logic                             w_new;

   assign act      = gdfs_pkg::action_type'(req_action);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != gdfs_pkg::S_IDLE) || !out_free;

   assign src_ok  = XW'(req_source_vertex) < XW'(vcount_ff);
   assign dst_ok  = XW'(req_target_vertex) < XW'(vcount_ff);
   assign src_idx = VW'(req_source_vertex);
   assign dst_idx = VW'(req_target_vertex);
   assign w_idx   = VW'(ram_rdata);
   assign w_new   = (int'(ram_rdata) < MAX_VERTICES) && !visited_ff[w_idx];
   assign k_dec   = k_ff - KW'(1);
   assign below_idx = VW'(depth_ff - CW'(2));

   // memory addresses: entry k of vertex v sits at v * MAX_DEGREE + k
   assign ram_waddr = AW'(src_idx) * AW'(MAX_DEGREE) + AW'(cnt_ff[src_idx]);
   assign ram_raddr = AW'(cur_ff) * AW'(MAX_DEGREE) + AW'(k_dec);

   gdfs_nbr_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_nbr_ram (
      .clock    (clock),
      .ctl      (ram_ctl),
      .waddr    (ram_waddr),
      .wdata    (req_target_vertex),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   // sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      visited_in    = visited_ff;
      cnt_in        = cnt_ff;
      stack_in      = stack_ff;
      depth_in      = depth_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      cur_in        = cur_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vtx_in    = rsp_vtx_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      ram_ctl       = '0;

      unique case (state_ff)
         gdfs_pkg::S_IDLE: begin
            if (req_valid && !req_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_vtx_in    = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = gdfs_pkg::ST_OK;
               unique case (act)
                  gdfs_pkg::ACT_CLEAR: begin
                     vcount_in  = '0;
                     visited_in = '0;
                     cnt_in     = '{default: '0};
                  end
                  gdfs_pkg::ACT_ADD_VERTEX: begin
                     if (int'(vcount_ff) >= MAX_VERTICES) begin
                        rsp_status_in = gdfs_pkg::ST_GRAPH_FULL;
                     end else begin
                        vcount_in = vcount_ff + CW'(1);
                     end
                  end
                  gdfs_pkg::ACT_ADD_EDGE: begin
                     if (!src_ok || !dst_ok) begin
                        rsp_status_in = gdfs_pkg::ST_ABSENT;
                     end else if (int'(cnt_ff[src_idx]) >= MAX_DEGREE) begin
                        rsp_status_in = gdfs_pkg::ST_LIST_FULL;
                     end else begin
                        ram_ctl.we       = 1'b1;
                        cnt_in[src_idx]  = cnt_ff[src_idx] + KW'(1);
                     end
                  end
                  gdfs_pkg::ACT_SEARCH: begin
                     if (!dst_ok) begin
                        rsp_status_in = gdfs_pkg::ST_ABSENT;
                     end else begin
                        // start vertex is held back until we know whether it is the last
                        rsp_valid_in        = rsp_valid_ff && rsp_stall;
                        visited_in[dst_idx] = 1'b1;
                        stack_in[0]         = req_target_vertex;
                        depth_in            = CW'(1);
                        pend_in             = req_target_vertex;
                        n_in                = gdfs_pkg::RESULT_CNT_W'(1);
                        cur_in              = dst_idx;
                        k_in                = cnt_ff[dst_idx];
                        state_in            = gdfs_pkg::S_SCAN_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // issue a read of the next list entry, or pop when the list is used up
         gdfs_pkg::S_SCAN_RD: begin
            if (k_ff == '0) begin
               depth_in = depth_ff - CW'(1);
               if (depth_ff == CW'(1)) begin
                  state_in = gdfs_pkg::S_FINISH;
               end else begin
                  cur_in = VW'(stack_ff[below_idx]);
                  k_in   = cnt_ff[VW'(stack_ff[below_idx])];
               end
            end else begin
               ram_ctl.re = 1'b1;
               k_in       = k_dec;
               state_in   = gdfs_pkg::S_SCAN_CHK;
            end
         end

         // test the entry read; push a new vertex and emit the one before it, or finish at the result or stack limit
         gdfs_pkg::S_SCAN_CHK: begin
            if (!w_new) begin
               state_in = gdfs_pkg::S_SCAN_RD;
            end else if (int'(n_ff) >= gdfs_pkg::RESULT_LIMIT
                         || int'(depth_ff) >= MAX_VERTICES) begin
               state_in = gdfs_pkg::S_FINISH;
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_vtx_in                  = pend_ff;
               rsp_last_in                 = 1'b0;
               rsp_status_in               = gdfs_pkg::ST_OK;
               visited_in[w_idx]           = 1'b1;
               stack_in[VW'(depth_ff)]     = ram_rdata;
               depth_in                    = depth_ff + CW'(1);
               pend_in                     = ram_rdata;
               n_in                        = n_ff + gdfs_pkg::RESULT_CNT_W'(1);
               cur_in                      = w_idx;
               k_in                        = cnt_ff[w_idx];
               state_in                    = gdfs_pkg::S_SCAN_RD;
            end
         end

         // final vertex goes out with last set
         gdfs_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vtx_in    = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_status_in = gdfs_pkg::ST_OK;
               depth_in      = '0;
               state_in      = gdfs_pkg::S_IDLE;
            end
         end

         default: state_in = gdfs_pkg::S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdfs_pkg::S_IDLE;
         vcount_ff    <= '0;
         visited_ff   <= '0;
         cnt_ff       <= '{default: '0};
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         visited_ff   <= visited_in;
         cnt_ff       <= cnt_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      stack_ff      <= stack_in;
      n_ff          <= n_in;
      pend_ff       <= pend_in;
      cur_ff        <= cur_in;
      k_ff          <= k_in;
      rsp_vtx_ff    <= rsp_vtx_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vtx_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

   // a non-search transfer answers in the next cycle with a single last result
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action != gdfs_pkg::ACT_SEARCH)
      |=> (rsp_valid && rsp_last))
      else $error("non-search action did not answer at once");

   // results before the last one only come from a running search
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == gdfs_pkg::ST_OK))
      else $error("intermediate result with error status");

   // the stack is empty whenever the sequencer is idle
   a_idle_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::S_IDLE) |-> (depth_ff == '0))
      else $error("stack not empty in idle");

   // stack never exceeds the vertex limit
   a_depth_max: assert property (@(posedge clock) disable iff (reset)
      int'(depth_ff) <= MAX_VERTICES)
      else $error("stack overflow");

endmodule

>>> sim/gdfs_checker.sv
// gdfs_checker: watches the request and response channels of the search block,
// predicts each response from its own graph model and compares. Depends on gdfs_pkg.
`timescale 1ns / 1ps

module gdfs_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [gdfs_pkg::ACTION_W-1:0] req_action,
   input  logic [gdfs_pkg::VTX_W-1:0]    req_source_vertex,
   input  logic [gdfs_pkg::VTX_W-1:0]    req_target_vertex,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [gdfs_pkg::VTX_W-1:0]    rsp_visited_vertex,
   input  logic                          rsp_last,
   input  logic [gdfs_pkg::STATUS_W-1:0] rsp_status,
   output int                            fail_count,
   output int                            pending
);

   localparam int NV = gdfs_pkg::MAX_VERTICES_DEF;
   localparam int ND = gdfs_pkg::MAX_DEGREE_DEF;

   typedef struct packed {
      logic [gdfs_pkg::VTX_W-1:0] vtx;
      logic                       last;
      gdfs_pkg::status_type       status;
   } visit_type;

   visit_type  visit_q[$];
   int         num_vertices;
   logic       marked[NV];
   int         degree[NV];
   logic [gdfs_pkg::VTX_W-1:0] adj[NV][ND];

   function automatic void wipe_graph();
      num_vertices = 0;
      for (int v = 0; v < NV; v++) begin
         marked[v] = 1'b0;
         degree[v] = 0;
      end
   endfunction

   function automatic void push_visit(int v, logic l, gdfs_pkg::status_type s);
      visit_type r;
      r.vtx = v[gdfs_pkg::VTX_W-1:0];
      r.last = l;
      r.status = s;
      visit_q.push_back(r);
   endfunction

   // newest unvisited neighbor of v, -1 if none
   function automatic int next_unmarked(int v);
      for (int k = degree[v]; k > 0; k--)
         if (!marked[adj[v][k-1]]) return adj[v][k-1];
      return -1;
   endfunction

   // applies one request to the graph model and queues its responses
   function automatic void apply_request(gdfs_pkg::action_type act, int src, int dst);
      int path[$];
      int emitted;
      int w;
      case (act)
         gdfs_pkg::ACT_CLEAR: begin
            wipe_graph();
            push_visit(0, 1'b1, gdfs_pkg::ST_OK);
         end
         gdfs_pkg::ACT_ADD_VERTEX: begin
            if (num_vertices >= NV) push_visit(0, 1'b1, gdfs_pkg::ST_GRAPH_FULL);
            else begin
               num_vertices++;
               push_visit(0, 1'b1, gdfs_pkg::ST_OK);
            end
         end
         gdfs_pkg::ACT_ADD_EDGE: begin
            if (src >= num_vertices || dst >= num_vertices)
               push_visit(0, 1'b1, gdfs_pkg::ST_ABSENT);
            else if (degree[src] >= ND) push_visit(0, 1'b1, gdfs_pkg::ST_LIST_FULL);
            else begin
               adj[src][degree[src]] = dst[gdfs_pkg::VTX_W-1:0];
               degree[src]++;
               push_visit(0, 1'b1, gdfs_pkg::ST_OK);
            end
         end
         default: begin
            if (dst >= num_vertices) push_visit(0, 1'b1, gdfs_pkg::ST_ABSENT);
            else begin
               path.push_back(dst);
               marked[dst] = 1'b1;
               push_visit(dst, 1'b0, gdfs_pkg::ST_OK);
               emitted = 1;
               while (path.size() > 0) begin
                  w = next_unmarked(path[$]);
                  if (w < 0) begin
                     void'(path.pop_back());
                     continue;
                  end
                  if (emitted >= gdfs_pkg::RESULT_LIMIT || path.size() >= NV) break;
                  marked[w] = 1'b1;
                  path.push_back(w);
                  push_visit(w, 1'b0, gdfs_pkg::ST_OK);
                  emitted++;
               end
               visit_q[$].last = 1'b1;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      visit_type exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         wipe_graph();
         visit_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (visit_q.size() == 0) begin
               $error("unexpected response transfer: vertex %0d", rsp_visited_vertex);
               errs++;
            end else begin
               exp_r = visit_q.pop_front();
               if (rsp_visited_vertex !== exp_r.vtx) begin
                  $error("visited_vertex: expected %0d, actual %0d",
                         exp_r.vtx, rsp_visited_vertex);
                  errs++;
               end
               if (rsp_last !== exp_r.last) begin
                  $error("last: expected %0d, actual %0d", exp_r.last, rsp_last);
                  errs++;
               end
               if (rsp_status !== exp_r.status) begin
                  $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
                  errs++;
               end
            end
         end
         // predict after checking so a same-cycle response is never mistaken
         if (req_valid && !req_stall)
            apply_request(gdfs_pkg::action_type'(req_action), req_source_vertex,
                          req_target_vertex);
         fail_count <= fail_count + errs;
         pending <= visit_q.size();
      end
   end

endmodule

>>> sim/tb.sv
// tb: stimulus and verdict for graph_depth_first_search.
// Depends on gdfs_pkg, graph_depth_first_search and gdfs_checker.
`timescale 1ns / 1ps

module tb;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [gdfs_pkg::ACTION_W-1:0] req_action = gdfs_pkg::ACT_CLEAR;
   logic [gdfs_pkg::VTX_W-1:0]    req_source_vertex = '0;
   logic [gdfs_pkg::VTX_W-1:0]    req_target_vertex = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b1;
   logic [gdfs_pkg::VTX_W-1:0]    rsp_visited_vertex;
   logic                          rsp_last;
   logic [gdfs_pkg::STATUS_W-1:0] rsp_status;
   int                            fail_count;
   int                            pending;
   bit                            busy_stretch = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   graph_depth_first_search dut (.*);

   gdfs_checker chk (.*);

   // receiver back-pressure, none during the busy stretch
   always @(posedge clock)
      rsp_stall <= reset ? 1'b1 : (!busy_stretch && $urandom_range(99) < 36);

   // sends one request, with random idle cycles before it
   task automatic send_request(gdfs_pkg::action_type act, int src, int dst);
      while (!busy_stretch && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_source_vertex <= src[gdfs_pkg::VTX_W-1:0];
      req_target_vertex <= dst[gdfs_pkg::VTX_W-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic build_graph(int nv, int ne);
      send_request(gdfs_pkg::ACT_CLEAR, $urandom, $urandom);
      repeat (nv) send_request(gdfs_pkg::ACT_ADD_VERTEX, $urandom, $urandom);
      repeat (ne) send_request(gdfs_pkg::ACT_ADD_EDGE, $urandom_range(nv - 1),
                               $urandom_range(nv - 1));
   endtask

   initial begin
      int nv;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph, full graph, full list, duplicates, deep chain
      send_request(gdfs_pkg::ACT_SEARCH, 0, 0);
      send_request(gdfs_pkg::ACT_ADD_EDGE, 0, 0);
      repeat (17) send_request(gdfs_pkg::ACT_ADD_VERTEX, 15, 15);
      for (int v = 0; v < 3; v++) send_request(gdfs_pkg::ACT_ADD_EDGE, v, v + 1);
      send_request(gdfs_pkg::ACT_ADD_EDGE, 15, 0);
      send_request(gdfs_pkg::ACT_SEARCH, 15, 15);
      send_request(gdfs_pkg::ACT_SEARCH, 0, 0);
      repeat (17) send_request(gdfs_pkg::ACT_ADD_EDGE, 9, 9);
      send_request(gdfs_pkg::ACT_CLEAR, 15, 15);
      repeat (16) send_request(gdfs_pkg::ACT_ADD_VERTEX, 0, 0);
      for (int v = 0; v < 15; v++) send_request(gdfs_pkg::ACT_ADD_EDGE, v, v + 1);
      send_request(gdfs_pkg::ACT_ADD_EDGE, 15, 0);
      send_request(gdfs_pkg::ACT_SEARCH, 0, 5);

      // random: build graphs, then search them; some noise
      for (int g = 0; g < 22; g++) begin
         busy_stretch = (g >= 12 && g < 16);
         nv = (g % 7 == 0) ? 16 : $urandom_range(2, 8);
         build_graph(nv, $urandom_range(nv * 2));
         repeat ($urandom_range(1, 3)) begin
            send_request(gdfs_pkg::ACT_SEARCH, $urandom, $urandom_range(nv));
            if ($urandom_range(3) == 0)
               send_request(gdfs_pkg::action_type'($urandom_range(3)), $urandom,
                            $urandom);
         end
      end
      busy_stretch = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);

      fork
         wait (pending == 0);
         repeat (200000) @(posedge clock);
      join_any
      repeat (50) @(posedge clock);
      if (pending == 0 && fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> files.f
src/gdfs_pkg.sv
src/gdfs_nbr_ram.sv
src/graph_depth_first_search.sv
sim/gdfs_checker.sv
sim/tb.sv
